FILE: src/nva_pkg.sv
`default_nettype none
package nva_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_ON   = 2'd0;
  localparam logic [1:0] REQ_OFF  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_ALL  = 2'd3;

  // curve and steal selections
  localparam logic [1:0] CURVE_LOG = 2'd1;
  localparam logic [1:0] CURVE_SQ  = 2'd2;
  localparam logic [1:0] STEAL_OLD  = 2'd0;
  localparam logic [1:0] STEAL_NEW  = 2'd1;
  localparam logic [1:0] STEAL_HIGH = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_FIRST_NOTE   = 3'd0;
  localparam logic [2:0] REG_MIN_VELOCITY = 3'd1;
  localparam logic [2:0] REG_MIN_LEVEL    = 3'd2;
  localparam logic [2:0] REG_MAX_LEVEL    = 3'd3;
  localparam logic [2:0] REG_VOICE_LIMIT  = 3'd4;
  localparam logic [2:0] REG_STEAL_MODE   = 3'd5;
  localparam logic [2:0] REG_CURVE_MODE   = 3'd6;
  localparam logic [2:0] REG_MAX_HOLD_MS  = 3'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [1:0]  device_index;
    logic [3:0]  channel;
    logic [11:0] pwm_level;
    logic [6:0]  note_out;
    logic        status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  first_note;
    logic [6:0]  min_velocity;
    logic [11:0] min_level;
    logic [11:0] max_level;
    logic [6:0]  voice_limit;
    logic [1:0]  steal_mode;
    logic [1:0]  curve_mode;
    logic [31:0] max_hold_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_ON   = 3'd0,
    OP_OFF  = 3'd1,
    OP_TICK = 3'd2,
    OP_ALL  = 3'd3,
    OP_BAD  = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [6:0] offset;
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/nva_ram.sv
`default_nettype none
module nva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/nva_front.sv
`default_nettype none
module nva_front #(
  parameter int NUM_NOTES = 64
) (
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire nva_pkg::in_item_t in_data,
  input  wire nva_pkg::cfg_t    cfg,
  input  wire logic             q_ready,
  output logic                  q_push,
  output nva_pkg::cmd_t         q_cmd
);
  logic [6:0] diff;
  logic       bad;

  assign in_stall = !q_ready;
  assign q_push   = in_valid && q_ready;
  assign diff     = in_data.note - cfg.first_note;
  assign bad      = (in_data.note < cfg.first_note) || ({1'b0, diff} >= 8'(NUM_NOTES));

  // classify: low velocity note-on becomes note-off, out of range becomes bad
  always_comb begin
    q_cmd.note     = in_data.note;
    q_cmd.velocity = in_data.velocity;
    q_cmd.offset   = diff;
    case (in_data.req_type)
      nva_pkg::REQ_ON: begin
        if (bad) q_cmd.op = nva_pkg::OP_BAD;
        else if (in_data.velocity < cfg.min_velocity) q_cmd.op = nva_pkg::OP_OFF;
        else q_cmd.op = nva_pkg::OP_ON;
      end
      nva_pkg::REQ_OFF:  q_cmd.op = bad ? nva_pkg::OP_BAD : nva_pkg::OP_OFF;
      nva_pkg::REQ_TICK: q_cmd.op = nva_pkg::OP_TICK;
      default:           q_cmd.op = nva_pkg::OP_ALL;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/nva_queue.sv
`default_nettype none
module nva_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire nva_pkg::cmd_t push_cmd,
  output logic               ready,
  input  wire logic          pop,
  output logic               not_empty,
  output nva_pkg::cmd_t      head
);
  nva_pkg::cmd_t slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign ready     = cnt_r != 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

FILE: src/nva_back.sv
`default_nettype none
module nva_back #(
  parameter int NUM_NOTES           = 64,
  parameter int CHANNELS_PER_DEVICE = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire nva_pkg::cfg_t cfg,
  input  wire logic          q_not_empty,
  input  wire nva_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               ram_we,
  output logic [(NUM_NOTES > 1 ? $clog2(NUM_NOTES) : 1)-1:0] ram_waddr,
  output logic [31:0]        ram_wdata,
  output logic [(NUM_NOTES > 1 ? $clog2(NUM_NOTES) : 1)-1:0] ram_raddr,
  input  wire logic [31:0]   ram_rdata,
  output logic               out_valid,
  input  wire logic          out_stall,
  output nva_pkg::out_item_t out_data
);
  localparam int IDX_W   = NUM_NOTES > 1 ? $clog2(NUM_NOTES) : 1;
  localparam int TAB_N   = 2 ** IDX_W;
  localparam logic [63:0] LOG2_10_Q30 = 64'd3566893132;
  // ceil(2^33 / 127): exact quotient for every numerator below 2^26
  localparam logic [26:0] RECIP_127 = 27'd67637281;

  typedef logic [127:0][16:0] log_rom_t;
  typedef logic [TAB_N-1:0][1:0] dev_tab_t;
  typedef logic [TAB_N-1:0][3:0] ch_tab_t;

  function automatic logic [63:0] log2_q30(input logic [31:0] n);
    logic [63:0] y, r;
    int k;
    k = 0;
    for (int j = 0; j < 31; j++) begin
      if ((n >> (k + 1)) != 32'd0) k++;
    end
    y = ({32'd0, n} << 30) >> k;
    r = 64'(k) << 30;
    for (int b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t t;
    logic [63:0] hi, lo, d, q;
    lo = log2_q30(32'd127);
    for (int v = 0; v < 128; v++) begin
      hi = log2_q30(32'(127 + 9 * v));
      d  = hi > lo ? hi - lo : 64'd0;
      q  = ((d << 16) + LOG2_10_Q30 / 2) / LOG2_10_Q30;
      t[v] = q > 64'd65536 ? 17'd65536 : q[16:0];
    end
    return t;
  endfunction

  function automatic dev_tab_t build_dev_tab();
    dev_tab_t t;
    for (int i = 0; i < TAB_N; i++) t[i] = 2'(i / CHANNELS_PER_DEVICE);
    return t;
  endfunction

  function automatic ch_tab_t build_ch_tab();
    ch_tab_t t;
    for (int i = 0; i < TAB_N; i++) t[i] = 4'(i % CHANNELS_PER_DEVICE);
    return t;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();
  localparam dev_tab_t DEV_TAB = build_dev_tab();
  localparam ch_tab_t  CH_TAB  = build_ch_tab();

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_TREAD = 12'b000000000010,
    S_TCHK  = 12'b000000000100,
    S_FINAL = 12'b000000001000,
    S_SREAD = 12'b000000010000,
    S_SCHK  = 12'b000000100000,
    S_SREL  = 12'b000001000000,
    S_LVL1  = 12'b000010000000,
    S_LVL2  = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_ADD   = 12'b010000000000,
    S_ON    = 12'b100000000000
  } state_t;

  state_t             state_r, state_nxt;
  nva_pkg::cmd_t      cur_r, cur_nxt;
  logic [NUM_NOTES-1:0] active_r, active_nxt;
  logic [6:0]         count_r, count_nxt;
  logic [31:0]        ms_r, ms_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, pick_r, pick_nxt;
  logic [31:0]        pst_r, pst_nxt;
  logic               found_r, found_nxt;
  nva_pkg::out_item_t pend_r, pend_nxt;
  logic               havepend_r, havepend_nxt;
  logic [28:0]        prod_r, prod_nxt;
  logic [25:0]        num_r, num_nxt;
  logic               twice_r, twice_nxt;
  logic [12:0]        add_r, add_nxt;
  logic [11:0]        level_r, level_nxt;
  logic               out_valid_r, out_valid_nxt;
  nva_pkg::out_item_t out_r, out_nxt;

  logic [IDX_W-1:0]   cur_idx, head_idx;
  logic               slot_free, timed_out, last_idx;
  logic [11:0]        span;
  logic [52:0]        recip_prod;
  logic [19:0]        quo127;
  logic [12:0]        sum;
  nva_pkg::out_item_t empty_res;

  function automatic nva_pkg::out_item_t mk_wr(input logic [IDX_W-1:0] idx,
                                               input logic [11:0] lvl,
                                               input logic [6:0] first);
    nva_pkg::out_item_t r;
    r.write_valid  = 1'b1;
    r.device_index = DEV_TAB[idx];
    r.channel      = CH_TAB[idx];
    r.pwm_level    = lvl;
    r.note_out     = first + 7'(idx);
    r.status       = 1'b0;
    r.last         = 1'b0;
    return r;
  endfunction

  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign slot_free  = !out_valid_r || !out_stall;
  assign cur_idx    = cur_r.offset[IDX_W-1:0];
  assign head_idx   = q_head.offset[IDX_W-1:0];
  assign last_idx   = i_r == IDX_W'(NUM_NOTES - 1);
  assign span       = cfg.max_level - cfg.min_level;
  assign timed_out  = (ms_r - ram_rdata) > cfg.max_hold_ms;
  assign recip_prod = 53'(num_r) * 53'(RECIP_127);
  assign quo127     = recip_prod[52:33];
  assign sum        = {1'b0, cfg.min_level} + add_r;
  assign ram_raddr  = i_r;
  assign ram_waddr  = cur_idx;
  assign ram_wdata  = ms_r;

  always_comb begin
    empty_res = '0;
    if (cur_r.op == nva_pkg::OP_ON || cur_r.op == nva_pkg::OP_OFF ||
        cur_r.op == nva_pkg::OP_BAD) begin
      empty_res.note_out = cur_r.note;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    active_nxt    = active_r;
    count_nxt     = count_r;
    ms_nxt        = ms_r;
    i_nxt         = i_r;
    pick_nxt      = pick_r;
    pst_nxt       = pst_r;
    found_nxt     = found_r;
    pend_nxt      = pend_r;
    havepend_nxt  = havepend_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    twice_nxt     = twice_r;
    add_nxt       = add_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop        = 1'b1;
          cur_nxt      = q_head;
          havepend_nxt = 1'b0;
          i_nxt        = '0;
          found_nxt    = 1'b0;
          case (q_head.op)
            nva_pkg::OP_OFF: begin
              if (active_r[head_idx]) begin
                active_nxt[head_idx] = 1'b0;
                count_nxt            = count_r - 7'd1;
                pend_nxt             = mk_wr(head_idx, 12'd0, cfg.first_note);
                havepend_nxt         = 1'b1;
              end
              state_nxt = S_FINAL;
            end
            nva_pkg::OP_ON: begin
              if (cfg.voice_limit != 7'd0 && count_r >= cfg.voice_limit) state_nxt = S_SREAD;
              else state_nxt = S_LVL1;
            end
            nva_pkg::OP_TICK: begin
              ms_nxt    = ms_r + 32'd1;
              state_nxt = S_TREAD;
            end
            nva_pkg::OP_ALL: state_nxt = S_TREAD;
            default:         state_nxt = S_FINAL;
          endcase
        end
      end
      S_TREAD: state_nxt = S_TCHK;
      S_TCHK: begin
        // hold while a found release cannot push the pending one out
        if (!(active_r[i_r] && (cur_r.op == nva_pkg::OP_ALL || timed_out) &&
              havepend_r && !slot_free)) begin
          if (active_r[i_r] && (cur_r.op == nva_pkg::OP_ALL || timed_out)) begin
            if (havepend_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            active_nxt[i_r] = 1'b0;
            count_nxt       = count_r - 7'd1;
            pend_nxt        = mk_wr(i_r, 12'd0, cfg.first_note);
            havepend_nxt    = 1'b1;
          end
          if (last_idx) state_nxt = S_FINAL;
          else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_TREAD;
          end
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = havepend_r ? pend_r : empty_res;
          out_nxt.last   = 1'b1;
          out_nxt.status = cur_r.op == nva_pkg::OP_BAD;
          state_nxt      = S_IDLE;
        end
      end
      S_SREAD: state_nxt = S_SCHK;
      S_SCHK: begin
        if (active_r[i_r]) begin
          if (!found_r) begin
            pick_nxt  = i_r;
            pst_nxt   = ram_rdata;
            found_nxt = 1'b1;
          end else if ((cfg.steal_mode == nva_pkg::STEAL_OLD && ram_rdata < pst_r) ||
                       (cfg.steal_mode == nva_pkg::STEAL_NEW && ram_rdata > pst_r) ||
                       cfg.steal_mode == nva_pkg::STEAL_HIGH) begin
            pick_nxt = i_r;
            pst_nxt  = ram_rdata;
          end
        end
        if (last_idx) state_nxt = S_SREL;
        else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_SREAD;
        end
      end
      S_SREL: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = mk_wr(pick_r, 12'd0, cfg.first_note);
          active_nxt[pick_r]   = 1'b0;
          count_nxt            = count_r - 7'd1;
          state_nxt            = S_LVL1;
        end
      end
      S_LVL1: begin
        if (cfg.max_level < cfg.min_level) begin
          level_nxt = cfg.max_level;
          state_nxt = S_ON;
        end else begin
          if (cfg.curve_mode == nva_pkg::CURVE_LOG) begin
            prod_nxt = 29'(span) * 29'(LOG_ROM[cur_r.velocity]);
          end else begin
            prod_nxt = 29'(span) * 29'(cur_r.velocity);
          end
          state_nxt = S_LVL2;
        end
      end
      S_LVL2: begin
        if (cfg.curve_mode == nva_pkg::CURVE_LOG) begin
          add_nxt   = prod_r[28:16];
          state_nxt = S_ADD;
        end else if (cfg.curve_mode == nva_pkg::CURVE_SQ) begin
          num_nxt   = 26'(prod_r[18:0]) * 26'(cur_r.velocity);
          twice_nxt = 1'b1;
          state_nxt = S_DIV;
        end else begin
          num_nxt   = prod_r[25:0];
          twice_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // divide by 127 with a reciprocal multiply; the squared curve passes twice
        if (twice_r) begin
          num_nxt   = 26'(quo127);
          twice_nxt = 1'b0;
        end else begin
          add_nxt   = quo127[12:0];
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        level_nxt = sum > {1'b0, cfg.max_level} ? cfg.max_level : sum[11:0];
        state_nxt = S_ON;
      end
      S_ON: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = mk_wr(cur_idx, level_r, cfg.first_note);
          out_nxt.last         = 1'b1;
          active_nxt[cur_idx]  = 1'b1;
          if (!active_r[cur_idx]) count_nxt = count_r + 7'd1;
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      count_r     <= '0;
      ms_r        <= '0;
      havepend_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      ms_r        <= ms_nxt;
      havepend_r  <= havepend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r   <= cur_nxt;
    i_r     <= i_nxt;
    pick_r  <= pick_nxt;
    pst_r   <= pst_nxt;
    pend_r  <= pend_nxt;
    prod_r  <= prod_nxt;
    num_r   <= num_nxt;
    twice_r <= twice_nxt;
    add_r   <= add_nxt;
    level_r <= level_nxt;
    out_r   <= out_nxt;
  end
endmodule
`default_nettype wire

FILE: src/note_voice_allocator_pwm.sv
`default_nettype none
// Polyphonic note allocator for PWM-driven solenoids. Each input item is a
// note-on, note-off, millisecond tick or all-notes-off request; the block
// answers with one or more result items, each a PWM channel write (or an empty
// result when nothing is written), the final one flagged by last and carrying
// status. A front end classifies items and drops them into a two-entry queue,
// so the input keeps moving while the back end works; an output register lets
// the back end hand over a result while the next one is prepared. A note-off
// or bad note goes straight to its final result; a note-on runs through the
// level pipeline, with one reciprocal-multiply divide by 127 for the linear
// curve and two for the squared, or skips it when the levels are inverted;
// stealing first scans the start-time RAM. A tick or all-off scans the
// start-time RAM one entry at a time through its single registered read port.
// A result held by out_stall delays the back end. Configuration must be
// written by the user through cfg_wr_en/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
module note_voice_allocator_pwm #(
  parameter int NUM_NOTES           = 64,
  parameter int CHANNELS_PER_DEVICE = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire nva_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output nva_pkg::out_item_t      out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  localparam int IDX_W = NUM_NOTES > 1 ? $clog2(NUM_NOTES) : 1;

  nva_pkg::cfg_t cfg_r, cfg_nxt;
  logic          q_ready, q_push, q_pop, q_not_empty;
  nva_pkg::cmd_t q_cmd, q_head;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  // register file: take the low bits of the write data for the addressed field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        nva_pkg::REG_FIRST_NOTE:   cfg_nxt.first_note   = cfg_data[6:0];
        nva_pkg::REG_MIN_VELOCITY: cfg_nxt.min_velocity = cfg_data[6:0];
        nva_pkg::REG_MIN_LEVEL:    cfg_nxt.min_level    = cfg_data[11:0];
        nva_pkg::REG_MAX_LEVEL:    cfg_nxt.max_level    = cfg_data[11:0];
        nva_pkg::REG_VOICE_LIMIT:  cfg_nxt.voice_limit  = cfg_data[6:0];
        nva_pkg::REG_STEAL_MODE:   cfg_nxt.steal_mode   = cfg_data[1:0];
        nva_pkg::REG_CURVE_MODE:   cfg_nxt.curve_mode   = cfg_data[1:0];
        nva_pkg::REG_MAX_HOLD_MS:  cfg_nxt.max_hold_ms  = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_note   <= 7'd21;
      cfg_r.min_velocity <= 7'd1;
      cfg_r.min_level    <= 12'd0;
      cfg_r.max_level    <= 12'd4095;
      cfg_r.voice_limit  <= 7'd0;
      cfg_r.steal_mode   <= 2'd0;
      cfg_r.curve_mode   <= 2'd0;
      cfg_r.max_hold_ms  <= 32'd5000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  nva_front #(.NUM_NOTES(NUM_NOTES)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // decouple front and back
  nva_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .ready     (q_ready),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // start time of each note, only used for sounding notes
  nva_ram #(.WIDTH(32), .DEPTH(NUM_NOTES)) u_start_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: note state, scans, level curve and result register
  nva_back #(
    .NUM_NOTES           (NUM_NOTES),
    .CHANNELS_PER_DEVICE (CHANNELS_PER_DEVICE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );
endmodule
`default_nettype wire

FILE: src/nva_chk.sv
`default_nettype none
module nva_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire nva_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_valid |->
      out_data.device_index == 2'd0 && out_data.channel == 4'd0 &&
      out_data.pwm_level == 12'd0)
    else $error("empty result carries write fields");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && !out_data.write_valid)
    else $error("status on a non-final or write result");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pwm_level != 12'd0 |-> out_data.last)
    else $error("nonzero level before the final result");
endmodule

bind note_voice_allocator_pwm nva_chk u_nva_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int NOTES   = 64;
  localparam int CHPD    = 16;
  localparam int SETTLE  = 300;   // cycles after the last result before a register write
  localparam longint unsigned LOG2_10 = 64'd3566893132;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  nva_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nva_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  note_voice_allocator_pwm DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the allocator: registers, note table and the ms clock
  nva_pkg::cfg_t shadow_cfg;
  bit          note_on_flag [NOTES];
  logic [31:0] note_start [NOTES];
  logic [31:0] ms_clock;

  nva_pkg::out_item_t write_q[$];     // expected writes, oldest first
  nva_pkg::out_item_t item_writes[$]; // writes of the item being predicted

  int errors = 0;
  int items_sent = 0;
  int writes_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint unsigned log2_fix(int unsigned n);
    int unsigned k;
    longint unsigned y, r, t;
    k = 0;
    if (n == 0) return 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    t = n;
    y = (t << 30) >> k;
    r = longint'(k) << 30;
    for (int b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

  function automatic logic [11:0] velocity_level(int unsigned v);
    longint unsigned s, add, hi, lo, d, q;
    if (shadow_cfg.max_level < shadow_cfg.min_level) return shadow_cfg.max_level;
    s = shadow_cfg.max_level - shadow_cfg.min_level;
    case (shadow_cfg.curve_mode)
      nva_pkg::CURVE_LOG: begin
        hi = log2_fix(127 + 9 * v);
        lo = log2_fix(127);
        d = (hi > lo) ? hi - lo : 0;
        q = ((d << 16) + LOG2_10 / 2) / LOG2_10;
        if (q > 65536) q = 65536;
        add = (s * q) >> 16;
      end
      nva_pkg::CURVE_SQ: add = s * v * v / 16129;
      default:  add = s * v / 127;
    endcase
    add = add + shadow_cfg.min_level;
    if (add > shadow_cfg.max_level) add = shadow_cfg.max_level;
    return add[11:0];
  endfunction

  function automatic void add_write(bit valid, int unsigned idx, logic [11:0] lvl,
                                    logic [6:0] note);
    nva_pkg::out_item_t w;
    w = '0;
    w.write_valid = valid;
    w.device_index = valid ? 2'((idx / CHPD) & 3) : 2'd0;
    w.channel = valid ? 4'(idx % CHPD) : 4'd0;
    w.pwm_level = lvl;
    w.note_out = note;
    item_writes.push_back(w);
  endfunction

  function automatic void silence_note(int unsigned idx);
    if (idx >= NOTES || !note_on_flag[idx]) return;
    note_on_flag[idx] = 1'b0;
    note_start[idx] = '0;
    add_write(1'b1, idx, 12'd0, 7'(shadow_cfg.first_note + idx));
  endfunction

  function automatic void steal_voice();
    int unsigned cnt, pick;
    bit found;
    cnt = 0;
    pick = 0;
    found = 1'b0;
    for (int i = 0; i < NOTES; i++) if (note_on_flag[i]) cnt++;
    if (shadow_cfg.voice_limit == 0 || cnt < shadow_cfg.voice_limit) return;
    for (int i = 0; i < NOTES; i++) begin
      if (!note_on_flag[i]) continue;
      if (!found) begin
        pick = i;
        found = 1'b1;
        continue;
      end
      if (shadow_cfg.steal_mode == nva_pkg::STEAL_OLD && note_start[i] < note_start[pick])
        pick = i;
      else if (shadow_cfg.steal_mode == nva_pkg::STEAL_NEW &&
               note_start[i] > note_start[pick])
        pick = i;
      else if (shadow_cfg.steal_mode == nva_pkg::STEAL_HIGH) pick = i;
    end
    if (found) silence_note(pick);
  endfunction

  // Work out every write one accepted item causes and queue them
  function automatic void predict_writes(nva_pkg::in_item_t it);
    bit stat;
    int unsigned idx;
    nva_pkg::out_item_t w;
    stat = 1'b0;
    item_writes.delete();
    if (it.req_type == nva_pkg::REQ_ON || it.req_type == nva_pkg::REQ_OFF) begin
      if (it.note < shadow_cfg.first_note || it.note - shadow_cfg.first_note >= NOTES) begin
        stat = 1'b1;
      end else begin
        idx = it.note - shadow_cfg.first_note;
        if (it.req_type == nva_pkg::REQ_OFF || it.velocity < shadow_cfg.min_velocity) begin
          silence_note(idx);
        end else begin
          steal_voice();
          add_write(1'b1, idx, velocity_level(it.velocity), it.note);
          note_on_flag[idx] = 1'b1;
          note_start[idx] = ms_clock;
        end
      end
    end else if (it.req_type == nva_pkg::REQ_TICK) begin
      ms_clock = ms_clock + 32'd1;
      for (int i = 0; i < NOTES; i++)
        if (note_on_flag[i] && (ms_clock - note_start[i]) > shadow_cfg.max_hold_ms)
          silence_note(i);
    end else begin
      for (int i = 0; i < NOTES; i++) silence_note(i);
    end
    if (item_writes.size() == 0)
      add_write(1'b0, 0, 12'd0,
                (it.req_type == nva_pkg::REQ_ON || it.req_type == nva_pkg::REQ_OFF) ?
                it.note : 7'd0);
    w = item_writes.pop_back();
    w.status = stat;
    w.last = 1'b1;
    item_writes.push_back(w);
    foreach (item_writes[i]) write_q.push_back(item_writes[i]);
  endfunction

  // Drive one item after a random gap; hold it until accepted
  task automatic send_item(logic [1:0] req, logic [6:0] note, logic [6:0] vel);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{req_type: req, note: note, velocity: vel};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_writes('{req_type: req, note: note, velocity: vel});
    items_sent++;
  endtask

  // Drop valid, wait for every expected write, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (write_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      nva_pkg::REG_FIRST_NOTE:   shadow_cfg.first_note = val[6:0];
      nva_pkg::REG_MIN_VELOCITY: shadow_cfg.min_velocity = val[6:0];
      nva_pkg::REG_MIN_LEVEL:    shadow_cfg.min_level = val[11:0];
      nva_pkg::REG_MAX_LEVEL:    shadow_cfg.max_level = val[11:0];
      nva_pkg::REG_VOICE_LIMIT:  shadow_cfg.voice_limit = val[6:0];
      nva_pkg::REG_STEAL_MODE:   shadow_cfg.steal_mode = val[1:0];
      nva_pkg::REG_CURVE_MODE:   shadow_cfg.curve_mode = val[1:0];
      default:                   shadow_cfg.max_hold_ms = val;
    endcase
  endtask

  // Receiver: stall at random, decided on the falling edge
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Check each accepted write against the oldest expectation
  always @(posedge clk) begin
    nva_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      writes_seen++;
      if (write_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected write, actual %p", $time, out_data);
      end else begin
        want = write_q.pop_front();
        if (out_data.write_valid !== want.write_valid ||
            out_data.device_index !== want.device_index ||
            out_data.channel !== want.channel ||
            out_data.pwm_level !== want.pwm_level ||
            out_data.note_out !== want.note_out ||
            out_data.status !== want.status ||
            out_data.last !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected %p actual %p", $time, want, out_data);
        end
      end
    end
  end

  // Range edges, empty results, off of a silent note, all request kinds
  task automatic test_basic();
    send_item(nva_pkg::REQ_ON, 7'd0, 7'd127);    // below mapped range
    send_item(nva_pkg::REQ_OFF, 7'd127, 7'd0);   // above mapped range
    send_item(nva_pkg::REQ_ON, 7'd21, 7'd127);
    send_item(nva_pkg::REQ_ON, 7'd84, 7'd1);     // top index, lowest accepted velocity
    send_item(nva_pkg::REQ_ON, 7'd84, 7'd64);    // rewrite a sounding note
    send_item(nva_pkg::REQ_ON, 7'd40, 7'd0);     // low velocity acts as off of silent note
    send_item(nva_pkg::REQ_OFF, 7'd50, 7'd127);  // off of silent note
    send_item(nva_pkg::REQ_ON, 7'd21, 7'd0);     // low velocity releases
    send_item(nva_pkg::REQ_TICK, 7'd127, 7'd127);
    send_item(nva_pkg::REQ_ALL, 7'd5, 7'd9);
    send_item(nva_pkg::REQ_ALL, 7'd0, 7'd0);     // nothing left
  endtask

  // Each curve, with inverted and equal levels
  task automatic test_curves();
    for (int c = 0; c < 4; c++) begin
      write_reg(nva_pkg::REG_CURVE_MODE, c);
      send_item(nva_pkg::REQ_ON, 7'd30, 7'd127);
      send_item(nva_pkg::REQ_ON, 7'd31, 7'd45);
    end
    write_reg(nva_pkg::REG_MIN_LEVEL, 4095);
    write_reg(nva_pkg::REG_MAX_LEVEL, 0);
    send_item(nva_pkg::REQ_ON, 7'd32, 7'd100);   // inverted levels give max_level
    write_reg(nva_pkg::REG_MAX_LEVEL, 4095);
    send_item(nva_pkg::REQ_ON, 7'd33, 7'd100);
    write_reg(nva_pkg::REG_MIN_LEVEL, 0);
    send_item(nva_pkg::REQ_ALL, 7'd0, 7'd0);
  endtask

  // Full voice table in each steal mode, including ties in start time
  task automatic test_stealing();
    write_reg(nva_pkg::REG_VOICE_LIMIT, 3);
    for (int m = 0; m < 4; m++) begin
      write_reg(nva_pkg::REG_STEAL_MODE, m);
      send_item(nva_pkg::REQ_ON, 7'd40, 7'd90);
      send_item(nva_pkg::REQ_TICK, 7'd0, 7'd0);
      send_item(nva_pkg::REQ_ON, 7'd25, 7'd90);
      send_item(nva_pkg::REQ_ON, 7'd60, 7'd90);
      send_item(nva_pkg::REQ_ON, 7'd25, 7'd70);  // steal even though it sounds
      send_item(nva_pkg::REQ_ALL, 7'd0, 7'd0);
    end
    write_reg(nva_pkg::REG_VOICE_LIMIT, 0);
  endtask

  // Hold limits zero and maximum
  task automatic test_timeout();
    write_reg(nva_pkg::REG_MAX_HOLD_MS, 0);
    send_item(nva_pkg::REQ_ON, 7'd22, 7'd50);
    send_item(nva_pkg::REQ_ON, 7'd23, 7'd50);
    send_item(nva_pkg::REQ_TICK, 7'd0, 7'd0);
    write_reg(nva_pkg::REG_MAX_HOLD_MS, 32'hFFFF_FFFF);
    send_item(nva_pkg::REQ_ON, 7'd22, 7'd50);
    send_item(nva_pkg::REQ_TICK, 7'd0, 7'd0);
    send_item(nva_pkg::REQ_ALL, 7'd0, 7'd0);
  endtask

  task automatic random_settings();
    int r;
    r = $urandom_range(9);
    write_reg(nva_pkg::REG_FIRST_NOTE, (r == 0) ? 0 : (r == 1) ? 127 : $urandom_range(64));
    r = $urandom_range(9);
    write_reg(nva_pkg::REG_MIN_VELOCITY, (r == 0) ? 0 : (r == 1) ? 127 : $urandom_range(20));
    write_reg(nva_pkg::REG_MIN_LEVEL, ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                              : $urandom_range(600));
    write_reg(nva_pkg::REG_MAX_LEVEL, ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                              : $urandom_range(3500, 4095));
    r = $urandom_range(9);
    write_reg(nva_pkg::REG_VOICE_LIMIT, (r == 0) ? 0 : (r == 1) ? 64 : $urandom_range(1, 8));
    write_reg(nva_pkg::REG_STEAL_MODE, $urandom_range(3));
    write_reg(nva_pkg::REG_CURVE_MODE, $urandom_range(3));
    r = $urandom_range(9);
    write_reg(nva_pkg::REG_MAX_HOLD_MS,
              (r == 0) ? $urandom() : (r == 1) ? 0 : $urandom_range(40));
  endtask

  // Random traffic in four idling phases, settings changed every 30 items
  task automatic test_random();
    int r;
    logic [1:0] req;
    logic [6:0] note;
    int unsigned base;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 34 : 0;
      for (int n = 0; n < 80; n++) begin
        if (n % 30 == 0) random_settings();
        r = $urandom_range(99);
        req = (r < 50) ? nva_pkg::REQ_ON : (r < 75) ? nva_pkg::REQ_OFF :
              (r < 95) ? nva_pkg::REQ_TICK : nva_pkg::REQ_ALL;
        base = shadow_cfg.first_note + $urandom_range(15);
        note = ($urandom_range(9) == 0 || base > 127) ? 7'($urandom()) : 7'(base);
        send_item(req, note, 7'($urandom()));
      end
    end
  endtask

  initial begin
    shadow_cfg = '{first_note: 7'd21, min_velocity: 7'd1, min_level: 12'd0,
                   max_level: 12'd4095, voice_limit: 7'd0, steal_mode: 2'd0,
                   curve_mode: 2'd0, max_hold_ms: 32'd5000};
    foreach (note_on_flag[i]) begin
      note_on_flag[i] = 1'b0;
      note_start[i] = '0;
    end
    ms_clock = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic();
    test_curves();
    test_stealing();
    test_timeout();
    test_random();
    drain();
    $display("Sent %0d items and checked %0d writes over curves, stealing, timeouts",
             items_sent, writes_seen);
    $display("and random settings under four idling phases.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #20ms;
    $display("timeout with %0d writes outstanding", write_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/nva_pkg.sv
src/nva_ram.sv
src/nva_front.sv
src/nva_queue.sv
src/nva_back.sv
src/note_voice_allocator_pwm.sv
src/nva_chk.sv
tb/sv/tb_top.sv
